@@ hw/rtl/tmtw_pkg.sv @@
`timescale 1ns / 1ps

package tmtw_pkg;

	localparam int ROW_W = 5;
	localparam int COL_W = 7;
	localparam int LIN_W = 11;

	localparam logic [1:0] ACT_PUT    = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_SETPOS = 2'd2;

	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_RETURN   = 8'd13;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h07;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_TEXT_COLOR = '0;

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       char_code;
		logic [ROW_W-1:0] target_row;
		logic [COL_W-1:0] target_col;
	} req_t;

	typedef struct packed {
		logic [7:0]       cell_char;
		logic [7:0]       cell_color;
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
		logic [LIN_W-1:0] cursor_linear;
		logic             scrolled;
		logic             ignored;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic latch;
		logic exec;
		logic blank;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_scroll;
		logic row_done;
	} sts_t;

endpackage

@@ hw/rtl/tmtw_if.sv @@
`timescale 1ns / 1ps

interface tmtw_req_if;
	logic          valid;
	logic          ready;
	tmtw_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tmtw_rsp_if;
	logic          valid;
	logic          ready;
	tmtw_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/tmtw_ctrl.sv @@
`timescale 1ns / 1ps

module tmtw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  tmtw_pkg::sts_t sts,
	output tmtw_pkg::cmd_t cmd
);

	tmtw_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmtw_pkg::ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			tmtw_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = tmtw_pkg::ST_IDLE;
				end
			end
			tmtw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = tmtw_pkg::ST_EXEC;
				end
			end
			tmtw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_scroll ? tmtw_pkg::ST_SCROLL : tmtw_pkg::ST_DONE;
			end
			tmtw_pkg::ST_SCROLL: begin
				cmd.blank = 1'b1;
				if (sts.row_done) begin
					state_d = tmtw_pkg::ST_DONE;
				end
			end
			tmtw_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = tmtw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmtw_pkg::ST_CLEAR;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ hw/rtl/tmtw_dp.sv @@
`timescale 1ns / 1ps

module tmtw_dp #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25,
	parameter int TAB_STOP    = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tmtw_pkg::cmd_t cmd,
	output tmtw_pkg::sts_t sts,
	input  tmtw_pkg::req_t req_data,
	input  logic [7:0]     text_color,
	output tmtw_pkg::rsp_t rsp_data
);

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = tmtw_pkg::ROW_W;
	localparam int COL_W  = tmtw_pkg::COL_W;
	localparam int LIN_W  = tmtw_pkg::LIN_W;
	localparam int TABN   = 2 ** COL_W;

	logic [15:0] mem [CELLS];
	logic [15:0] rd_q;

	tmtw_pkg::req_t   item_q;
	tmtw_pkg::rsp_t   rsp_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] top_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] clr_base_q;
	logic             scrolled_q;
	logic             ignored_q;
	logic             rd_ok_q;

	logic [COL_W:0] tab_next [TABN];

	for (genvar g = 0; g < TABN; g++) begin : g_tab
		localparam int NT = g + TAB_STOP - (g % TAB_STOP);
		assign tab_next[g] = (COL_W+1)'(NT);
	end

	// logical row to physical row of the circular screen
	logic [ROW_W-1:0] row_sel;
	logic [COL_W-1:0] col_sel;
	logic [ROW_W:0]   psum;
	logic [ROW_W-1:0] prow;
	logic [ADDR_W-1:0] exec_addr;

	always_comb begin
		row_sel   = (item_q.action == tmtw_pkg::ACT_READ) ? item_q.target_row : cur_row_q;
		col_sel   = (item_q.action == tmtw_pkg::ACT_READ) ? item_q.target_col : cur_col_q;
		psum      = {1'b0, row_sel} + {1'b0, top_q};
		prow      = (psum >= (ROW_W+1)'(SCREEN_ROWS)) ?
			ROW_W'(psum - (ROW_W+1)'(SCREEN_ROWS)) : psum[ROW_W-1:0];
		exec_addr = ADDR_W'(prow * SCREEN_COLS) + ADDR_W'(col_sel);
	end

	logic             is_nl, is_cr, is_tab, printable, in_range;
	logic [COL_W:0]   ncol;
	logic [ROW_W:0]   nrow;
	logic [COL_W-1:0] fcol;
	logic [ROW_W:0]   frow;
	logic             need_scroll;

	always_comb begin
		is_nl     = item_q.char_code == tmtw_pkg::CH_NEWLINE;
		is_cr     = item_q.char_code == tmtw_pkg::CH_RETURN;
		is_tab    = item_q.char_code == tmtw_pkg::CH_TAB;
		printable = !(is_nl || is_cr || is_tab);
		in_range  = (item_q.target_row < ROW_W'(SCREEN_ROWS)) &&
			(item_q.target_col < COL_W'(SCREEN_COLS));
		nrow = {1'b0, cur_row_q};
		ncol = {1'b0, cur_col_q} + (COL_W+1)'(1);
		if (is_nl) begin
			ncol = '0;
			nrow = {1'b0, cur_row_q} + (ROW_W+1)'(1);
		end else if (is_cr) begin
			ncol = '0;
		end else if (is_tab) begin
			ncol = tab_next[cur_col_q];
		end
		fcol = ncol[COL_W-1:0];
		frow = nrow;
		if (ncol >= (COL_W+1)'(SCREEN_COLS)) begin
			fcol = '0;
			frow = nrow + (ROW_W+1)'(1);
		end
		need_scroll = (item_q.action == tmtw_pkg::ACT_PUT) &&
			(frow >= (ROW_W+1)'(SCREEN_ROWS));
	end

	// memory port
	logic              we, re;
	logic [ADDR_W-1:0] addr;
	logic [15:0]       wdata;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		addr  = exec_addr;
		wdata = {text_color, item_q.char_code};
		if (cmd.clear) begin
			we    = 1'b1;
			addr  = cnt_q;
			wdata = {tmtw_pkg::RESET_COLOR, tmtw_pkg::BLANK_CHAR};
		end else if (cmd.blank) begin
			we    = 1'b1;
			addr  = clr_base_q + cnt_q;
			wdata = {text_color, tmtw_pkg::BLANK_CHAR};
		end else if (cmd.exec) begin
			we = (item_q.action == tmtw_pkg::ACT_PUT) && printable;
			re = (item_q.action == tmtw_pkg::ACT_READ) && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.clear) begin
				cnt_q <= (cnt_q == ADDR_W'(CELLS - 1)) ? '0 : cnt_q + ADDR_W'(1);
			end else if (cmd.blank) begin
				cnt_q <= (cnt_q == ADDR_W'(SCREEN_COLS - 1)) ? '0 : cnt_q + ADDR_W'(1);
			end
			if (cmd.exec) begin
				case (item_q.action)
					tmtw_pkg::ACT_PUT: begin
						cur_col_q <= fcol;
						if (need_scroll) begin
							cur_row_q <= ROW_W'(SCREEN_ROWS - 1);
							top_q     <= (top_q == ROW_W'(SCREEN_ROWS - 1)) ?
								'0 : top_q + ROW_W'(1);
						end else begin
							cur_row_q <= frow[ROW_W-1:0];
						end
					end
					tmtw_pkg::ACT_SETPOS: begin
						if (in_range) begin
							cur_row_q <= item_q.target_row;
							cur_col_q <= item_q.target_col;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= req_data;
		end
		if (cmd.exec) begin
			clr_base_q <= ADDR_W'(top_q * SCREEN_COLS);
			scrolled_q <= need_scroll;
			rd_ok_q    <= (item_q.action == tmtw_pkg::ACT_READ) && in_range;
			case (item_q.action)
				tmtw_pkg::ACT_PUT:    ignored_q <= 1'b0;
				tmtw_pkg::ACT_READ:   ignored_q <= !in_range;
				tmtw_pkg::ACT_SETPOS: ignored_q <= !in_range;
				default:              ignored_q <= 1'b1;
			endcase
		end
		if (cmd.load_out) begin
			rsp_q.cell_char     <= rd_ok_q ? rd_q[7:0] : 8'd0;
			rsp_q.cell_color    <= rd_ok_q ? rd_q[15:8] : 8'd0;
			rsp_q.cursor_row    <= cur_row_q;
			rsp_q.cursor_col    <= cur_col_q;
			rsp_q.cursor_linear <= LIN_W'(cur_row_q * SCREEN_COLS + cur_col_q);
			rsp_q.scrolled      <= scrolled_q;
			rsp_q.ignored       <= ignored_q;
		end
	end

	assign sts.clear_done  = cmd.clear && (cnt_q == ADDR_W'(CELLS - 1));
	assign sts.row_done    = cnt_q == ADDR_W'(SCREEN_COLS - 1);
	assign sts.need_scroll = need_scroll;
	assign rsp_data        = rsp_q;

endmodule

@@ hw/rtl/text_mode_terminal_writer_top.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake       Beat
// req      in   valid / ready   action, char_code, target_row, target_col
// rsp      out  valid / ready   cell, cursor, cursor_linear, scrolled, ignored
// apb      in   psel / penable  text_color at byte address 0
//
// An item is accepted, executed and its result loaded; a put that scrolls
// also blanks the new bottom row of the circular screen before the load.
// After reset a clearing pass writes every cell, SCREEN_ROWS * SCREEN_COLS
// of them (2000 by default), during which req is not ready.
// The result register holds while rsp stalls; the next item is taken meanwhile.

module text_mode_terminal_writer_top #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25,
	parameter int TAB_STOP    = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tmtw_req_if.sink                    req,
	tmtw_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmtw_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	tmtw_pkg::cmd_t cmd;
	tmtw_pkg::sts_t sts;
	logic [7:0]     color_q;
	logic           reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[tmtw_pkg::APB_AW-1:2] == tmtw_pkg::REG_TEXT_COLOR) &&
		(paddr[1:0] == 2'd0);
	assign prdata  = reg_hit ? {24'd0, color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tmtw_pkg::RESET_COLOR;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			color_q <= pwdata[7:0];
		end
	end

	tmtw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tmtw_dp #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.TAB_STOP    (TAB_STOP)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_data   (req.payload),
		.text_color (color_q),
		.rsp_data   (rsp.payload)
	);

endmodule

@@ tb/tb_text_mode_terminal_writer_top.sv @@
`timescale 1ns / 1ps

module tb_text_mode_terminal_writer_top;
	import tmtw_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int TAB = 4;
	localparam int CELLS = COLS * ROWS;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int LIMIT = 1000000;

	class term_scoreboard;
		bit [15:0] cells [CELLS];
		int unsigned row;
		int unsigned col;
		logic [7:0] color;
		rsp_t expected_q [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < CELLS; i++)
				cells[i] = {RESET_COLOR, BLANK_CHAR};
			row = 0;
			col = 0;
			color = RESET_COLOR;
			errors = 0;
		endfunction

		function bit put_char(logic [7:0] ch);
			bit rolled;
			rolled = 0;
			if (ch == CH_NEWLINE) begin
				col = 0;
				row++;
			end else if (ch == CH_RETURN) begin
				col = 0;
			end else if (ch == CH_TAB) begin
				col = col + TAB - (col % TAB);
			end else begin
				cells[row * COLS + col] = {color, ch};
				col++;
			end
			if (col >= COLS) begin
				col = 0;
				row++;
			end
			if (row >= ROWS) begin
				for (int i = 0; i < CELLS - COLS; i++)
					cells[i] = cells[i + COLS];
				for (int i = CELLS - COLS; i < CELLS; i++)
					cells[i] = {color, BLANK_CHAR};
				row = ROWS - 1;
				rolled = 1;
			end
			return rolled;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			bit fits;
			e = '0;
			fits = (r.target_row < ROWS) && (r.target_col < COLS);
			case (r.action)
				ACT_PUT: e.scrolled = put_char(r.char_code);
				ACT_READ: begin
					if (fits)
						{e.cell_color, e.cell_char} = cells[r.target_row * COLS + r.target_col];
					else
						e.ignored = 1;
				end
				ACT_SETPOS: begin
					if (fits) begin
						row = r.target_row;
						col = r.target_col;
					end else begin
						e.ignored = 1;
					end
				end
				default: e.ignored = 1;
			endcase
			e.cursor_row = ROW_W'(row);
			e.cursor_col = COL_W'(col);
			e.cursor_linear = LIN_W'(row * COLS + col);
			expected_q.push_back(e);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, want, got);
			end
		endfunction

		function void check_reply(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual %h", $time, got);
				return;
			end
			e = expected_q.pop_front();
			compare("cell_char", e.cell_char, got.cell_char);
			compare("cell_color", e.cell_color, got.cell_color);
			compare("cursor_row", e.cursor_row, got.cursor_row);
			compare("cursor_col", e.cursor_col, got.cursor_col);
			compare("cursor_linear", e.cursor_linear, got.cursor_linear);
			compare("scrolled", e.scrolled, got.scrolled);
			compare("ignored", e.ignored, got.ignored);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	bit calm;
	int cycles;

	tmtw_req_if req_ch ();
	tmtw_rsp_if rsp_ch ();

	term_scoreboard sb = new();

	text_mode_terminal_writer_top #(
		.SCREEN_COLS(COLS),
		.SCREEN_ROWS(ROWS),
		.TAB_STOP(TAB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic req_t mk(logic [1:0] a, logic [7:0] ch, int r, int c);
		req_t q;
		q.action = a;
		q.char_code = ch;
		q.target_row = ROW_W'(r);
		q.target_col = COL_W'(c);
		return q;
	endfunction

	task automatic send_request(req_t r);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic write_color(logic [7:0] c);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TEXT_COLOR, 2'b00};
		pwdata <= {24'b0, c};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.color = c;
	endtask

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// result side, with one long hold-off to back the block up
	initial begin
		int seen;
		int gap_left;
		int hold_left;
		bit held;
		int gap;
		seen = 0;
		gap_left = 0;
		hold_left = 0;
		held = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_reply(rsp_ch.payload);
				seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					rsp_ch.ready <= 1'b1;
			end else if (!held && seen >= HOLD_AFTER) begin
				held = 1;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				if (gap_left == 0)
					rsp_ch.ready <= 1'b1;
			end else begin
				gap = idle_len();
				gap_left = gap;
				rsp_ch.ready <= (gap == 0);
			end
		end
	end

	initial begin
		req_t dir [$];
		req_t r;
		logic [7:0] phase_color [PHASES];
		logic [7:0] c;
		int k;
		int s;

		phase_color = '{RESET_COLOR, 8'h00, 8'hFF, 8'h1E, 8'h00, 8'hF0, 8'h00};
		calm = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		dir.push_back(mk(ACT_READ, 8'h00, 0, 0));
		dir.push_back(mk(ACT_READ, 8'h00, ROWS - 1, COLS - 1));
		dir.push_back(mk(ACT_READ, 8'h00, ROWS, 0));
		dir.push_back(mk(ACT_READ, 8'h00, 0, COLS));
		dir.push_back(mk(ACT_READ, 8'hFF, 31, 127));
		dir.push_back(mk(ACT_SETPOS, 8'h00, ROWS, 5));
		dir.push_back(mk(ACT_SETPOS, 8'h00, 3, COLS));
		dir.push_back(mk(ACT_SETPOS, 8'h00, 31, 127));
		dir.push_back(mk(ACT_PUT, 8'h48, 0, 0));
		dir.push_back(mk(ACT_PUT, 8'h00, 31, 127));
		dir.push_back(mk(ACT_PUT, 8'hFF, 0, 0));
		dir.push_back(mk(ACT_PUT, CH_TAB, 0, 0));
		dir.push_back(mk(ACT_PUT, CH_RETURN, 0, 0));
		dir.push_back(mk(ACT_PUT, CH_NEWLINE, 0, 0));
		dir.push_back(mk(ACT_SETPOS, 8'h00, 2, COLS - 2));
		dir.push_back(mk(ACT_PUT, CH_TAB, 0, 0));
		dir.push_back(mk(ACT_SETPOS, 8'h00, 5, COLS - 4));
		dir.push_back(mk(ACT_PUT, CH_TAB, 0, 0));
		dir.push_back(mk(ACT_SETPOS, 8'h00, ROWS - 1, COLS - 1));
		dir.push_back(mk(ACT_PUT, 8'h5A, 0, 0));
		dir.push_back(mk(ACT_PUT, CH_NEWLINE, 0, 0));
		dir.push_back(mk(ACT_READ, 8'h00, ROWS - 3, COLS - 1));
		dir.push_back(mk(ACT_READ, 8'h00, ROWS - 1, 0));
		dir.push_back(mk(ACT_UNUSED, 8'hFF, 31, 127));
		dir.push_back(mk(ACT_SETPOS, 8'h00, 0, 0));
		foreach (dir[i])
			send_request(dir[i]);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				req_ch.valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
				c = (p == 4 || p == 6) ? 8'($urandom_range(0, 255)) : phase_color[p];
				write_color(c);
			end
			calm = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = req_t'($urandom);
				k = $urandom_range(0, 99);
				if (k < 60) begin
					r.action = ACT_PUT;
					s = $urandom_range(0, 99);
					if (s < 12)
						r.char_code = CH_NEWLINE;
					else if (s < 17)
						r.char_code = CH_RETURN;
					else if (s < 27)
						r.char_code = CH_TAB;
				end else if (k < 80) begin
					r.action = ACT_READ;
					if ($urandom_range(0, 99) < 85) begin
						r.target_row = ROW_W'($urandom_range(0, ROWS - 1));
						r.target_col = COL_W'($urandom_range(0, COLS - 1));
					end
				end else if (k < 95) begin
					r.action = ACT_SETPOS;
					if ($urandom_range(0, 99) < 80) begin
						// lean towards the bottom rows so that scrolling happens often
						r.target_row = ROW_W'($urandom_range(0, 1) ?
							$urandom_range(ROWS - 7, ROWS - 1) : $urandom_range(0, ROWS - 1));
						r.target_col = COL_W'($urandom_range(0, COLS - 1));
					end
				end else begin
					r.action = ACT_UNUSED;
				end
				send_request(r);
			end
		end
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
